### design/ohb_pkg.sv
// Shared types and constants of the OHLC bar aggregator.
package ohb_pkg;

    localparam int PW  = 40;   // price, volume and size width
    localparam int TW  = 48;   // timestamp width
    localparam int LW  = 27;   // window length width
    localparam int VW  = 56;   // turnover width
    localparam int SW  = 41;   // signed difference width
    localparam int NW  = 81;   // fair price numerator width

    localparam int IN_DATA_W  = 424;
    localparam int OUT_DATA_W = 464;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [LW-1:0] LEN_RESET = LW'(60000);

    localparam logic CFG_END_TIME = 1'b0;
    localparam logic CFG_LENGTH   = 1'b1;

    localparam int MUL_STEPS = 8;
    localparam int DIV_STEPS = PW;

    // One classified quote snapshot.
    typedef struct packed {
        logic          ok;
        logic          trade;
        logic          book;
        logic [PW-1:0] last_price;
        logic [PW-1:0] total_volume;
        logic [PW-1:0] last_volume;
        logic [VW-1:0] total_turnover;
        logic [PW-1:0] open_interest;
        logic [PW-1:0] bid_price;
        logic [PW-1:0] ask_price;
        logic [PW-1:0] bid_size;
        logic [PW-1:0] ask_size;
    } t_item;

    typedef struct packed {
        logic          start;
        logic [PW-1:0] bid_price;
        logic [PW-1:0] ask_price;
        logic [PW-1:0] bid_size;
        logic [PW-1:0] ask_size;
    } t_fair_req;

    typedef struct packed {
        logic          done;
        logic [PW-1:0] price;
    } t_fair_rsp;

endpackage

### design/ohb_front.sv
// Front end: window classification, configuration registers and the word queue.
module ohb_front #(
    parameter int QUEUE_DEPTH = ohb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [ohb_pkg::TW-1:0]          i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ohb_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_q_valid,
    output ohb_pkg::t_item                  o_q_item,
    input  logic                            i_q_pop
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ohb_pkg::TW-1:0] r_end_time;
    logic [ohb_pkg::LW-1:0] r_length;
    ohb_pkg::t_item         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]       r_count;

    logic [ohb_pkg::TW-1:0] qtime;
    logic [ohb_pkg::TW:0]   win_sum;
    logic                   push;
    ohb_pkg::t_item         item;

    assign qtime   = i_s_tdata[47:0];
    assign win_sum = {1'b0, qtime} + {(ohb_pkg::TW + 1 - ohb_pkg::LW)'(0), r_length};

    always_comb begin
        item.ok             = (qtime < r_end_time) && (win_sum >= {1'b0, r_end_time});
        item.trade          = i_s_tuser[0];
        item.book           = i_s_tuser[1];
        item.last_price     = i_s_tdata[87:48];
        item.total_volume   = i_s_tdata[127:88];
        item.last_volume    = i_s_tdata[167:128];
        item.total_turnover = i_s_tdata[223:168];
        item.open_interest  = i_s_tdata[263:224];
        item.bid_price      = i_s_tdata[303:264];
        item.ask_price      = i_s_tdata[343:304];
        item.bid_size       = i_s_tdata[383:344];
        item.ask_size       = i_s_tdata[423:384];
    end

    assign o_s_tready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_time <= '0;
            r_length   <= ohb_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ohb_pkg::CFG_END_TIME: r_end_time <= i_cfg_data;
                ohb_pkg::CFG_LENGTH:   r_length   <= i_cfg_data[ohb_pkg::LW-1:0];
                default:               r_length   <= r_length;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(push) - CNT_W'(i_q_pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("queue popped while empty");
endmodule

### design/ohb_fair.sv
// Fair price unit: serial partial-product multiply followed by a restoring divide.
module ohb_fair (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ohb_pkg::t_fair_req  i_req,
    output ohb_pkg::t_fair_rsp  o_rsp
);
    localparam int HW = ohb_pkg::PW / 2;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_LOAD = 4'b0100,
        F_DIV  = 4'b1000
    } t_fstate;

    t_fstate                r_state;
    logic [5:0]             r_step;
    logic [ohb_pkg::PW-1:0] r_bid, r_ask, r_bsz, r_asz;
    logic [ohb_pkg::NW-1:0] r_acc;
    logic [ohb_pkg::PW-1:0] r_prod;
    logic [1:0]             r_sh;
    logic                   r_pvalid;
    logic [ohb_pkg::SW-1:0] r_den;
    logic [ohb_pkg::SW-1:0] r_rem;
    logic [ohb_pkg::PW-1:0] r_num_lo;
    logic [ohb_pkg::PW-1:0] r_quot;
    logic                   r_done;

    logic [ohb_pkg::PW-1:0] op_a, op_b;
    logic [HW-1:0]          half_a, half_b;
    logic [ohb_pkg::NW-1:0] prod_sh;
    logic [ohb_pkg::SW:0]   rem_sh;
    logic                   rem_ge;

    always_comb begin
        op_a   = r_step[2] ? r_ask : r_bid;
        op_b   = r_step[2] ? r_bsz : r_asz;
        half_a = r_step[1] ? op_a[ohb_pkg::PW-1:HW] : op_a[HW-1:0];
        half_b = r_step[0] ? op_b[ohb_pkg::PW-1:HW] : op_b[HW-1:0];
        case (r_sh)
            2'd0:    prod_sh = {(ohb_pkg::NW - ohb_pkg::PW)'(0), r_prod};
            2'd1:    prod_sh = {(ohb_pkg::NW - ohb_pkg::PW - HW)'(0), r_prod, HW'(0)};
            default: prod_sh = {1'b0, r_prod, ohb_pkg::PW'(0)};
        endcase
        rem_sh = {r_rem, r_num_lo[ohb_pkg::PW-1]};
        rem_ge = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_done   <= 1'b0;
            r_pvalid <= 1'b0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_bid    <= i_req.bid_price;
                        r_ask    <= i_req.ask_price;
                        r_bsz    <= i_req.bid_size;
                        r_asz    <= i_req.ask_size;
                        r_den    <= {1'b0, i_req.bid_size} + {1'b0, i_req.ask_size};
                        r_acc    <= '0;
                        r_step   <= '0;
                        r_pvalid <= 1'b0;
                        r_state  <= F_MUL;
                    end
                end
                F_MUL: begin
                    if (r_pvalid) begin
                        r_acc <= r_acc + prod_sh;
                    end
                    if (r_step == 6'(ohb_pkg::MUL_STEPS)) begin
                        r_pvalid <= 1'b0;
                        r_state  <= F_LOAD;
                    end else begin
                        r_prod   <= half_a * half_b;
                        r_sh     <= 2'(r_step[1]) + 2'(r_step[0]);
                        r_pvalid <= 1'b1;
                        r_step   <= r_step + 1'b1;
                    end
                end
                F_LOAD: begin
                    // The quotient fits in one price, so the top bits already sit below den.
                    r_rem    <= r_acc[ohb_pkg::NW-1:ohb_pkg::PW];
                    r_num_lo <= r_acc[ohb_pkg::PW-1:0];
                    r_step   <= '0;
                    r_state  <= F_DIV;
                end
                F_DIV: begin
                    r_rem    <= rem_ge ? ohb_pkg::SW'(rem_sh - {1'b0, r_den})
                                       : rem_sh[ohb_pkg::SW-1:0];
                    r_quot   <= {r_quot[ohb_pkg::PW-2:0], rem_ge};
                    r_num_lo <= {r_num_lo[ohb_pkg::PW-2:0], 1'b0};
                    r_step   <= r_step + 1'b1;
                    r_done   <= (r_step == 6'(ohb_pkg::DIV_STEPS - 1));
                    if (r_step == 6'(ohb_pkg::DIV_STEPS - 1)) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.price = r_quot;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == F_IDLE) else $error("fair unit started while busy");
endmodule

### design/ohb_back.sv
// Back end: bar state update, fair price sequencing and the result register.
module ohb_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  ohb_pkg::t_item                  i_q_item,
    output logic                            o_q_pop,
    output ohb_pkg::t_fair_req              o_fair_req,
    input  ohb_pkg::t_fair_rsp              i_fair_rsp,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ohb_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tuser
);
    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_FAIR = 2'b10
    } t_bstate;

    t_bstate                r_state;
    logic                   r_out_valid, r_out_ok;
    logic [ohb_pkg::PW-1:0] r_open, r_high, r_low, r_close, r_vol;
    logic [ohb_pkg::VW-1:0] r_turn;
    logic [ohb_pkg::SW-1:0] r_idelta, r_spread;
    logic [ohb_pkg::PW-1:0] r_micro, r_mid, r_depth;
    logic [ohb_pkg::PW-1:0] r_base_vol, r_base_oi, r_seen_vol;
    logic [ohb_pkg::VW-1:0] r_base_turn;

    ohb_pkg::t_item         it;
    logic                   do_trade, do_book, first;
    logic [ohb_pkg::SW-1:0] den, mid_sum;

    assign it       = i_q_item;
    assign o_q_pop  = (r_state == B_IDLE) && !r_out_valid && i_q_valid;
    assign do_trade = it.ok && it.trade && (r_seen_vol != it.total_volume);
    assign do_book  = it.ok && it.book;
    assign first    = (r_base_vol == '0);
    assign den      = {1'b0, it.bid_size} + {1'b0, it.ask_size};
    assign mid_sum  = {1'b0, it.bid_price} + {1'b0, it.ask_price};

    always_comb begin
        o_fair_req.start     = o_q_pop && do_book && (den != '0);
        o_fair_req.bid_price = it.bid_price;
        o_fair_req.ask_price = it.ask_price;
        o_fair_req.bid_size  = it.bid_size;
        o_fair_req.ask_size  = it.ask_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_out_ok    <= 1'b0;
            r_open <= '0; r_high <= '0; r_low <= '0; r_close <= '0;
            r_vol <= '0; r_turn <= '0; r_idelta <= '0; r_micro <= '0;
            r_spread <= '0; r_mid <= '0; r_depth <= '0;
            r_base_vol <= '0; r_base_turn <= '0; r_base_oi <= '0; r_seen_vol <= '0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_q_pop) begin
                        r_out_ok <= it.ok;
                        if (do_trade) begin
                            r_seen_vol <= it.total_volume;
                            r_close    <= it.last_price;
                            if (first) begin
                                r_open      <= it.last_price;
                                r_high      <= it.last_price;
                                r_low       <= it.last_price;
                                r_vol       <= it.last_volume;
                                r_base_vol  <= it.total_volume;
                                r_base_turn <= it.total_turnover;
                                r_base_oi   <= it.open_interest;
                                r_idelta    <= '0;
                            end else begin
                                if (it.last_price > r_high) r_high <= it.last_price;
                                if (it.last_price < r_low)  r_low  <= it.last_price;
                                r_vol  <= (it.total_volume > r_base_vol)
                                          ? it.total_volume - r_base_vol : '0;
                                r_turn <= (it.total_turnover > r_base_turn)
                                          ? it.total_turnover - r_base_turn : '0;
                                r_idelta <= {1'b0, it.open_interest} - {1'b0, r_base_oi};
                            end
                        end
                        if (do_book) begin
                            r_spread <= {1'b0, it.ask_price} - {1'b0, it.bid_price};
                            r_mid    <= mid_sum[ohb_pkg::SW-1:1];
                            r_depth  <= den[ohb_pkg::SW-1:1];
                        end
                        if (o_fair_req.start) begin
                            r_state <= B_FAIR;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                B_FAIR: begin
                    if (i_fair_rsp.done) begin
                        r_micro     <= i_fair_rsp.price;
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_ok;
    assign o_m_tdata  = {6'b0, r_depth, r_mid, r_spread, r_micro, r_idelta,
                         r_turn, r_vol, r_close, r_low, r_high, r_open};

    a_fair_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fair_rsp.done |-> r_state == B_FAIR) else $error("fair result with no request");
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_FAIR |-> !r_out_valid) else $error("result shown while fair busy");
    a_result_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && !o_fair_req.start) |=> r_out_valid) else $error("result lost");
endmodule

### design/ohlc_bar_aggregator_core.sv
// Top level of the OHLC bar aggregator.
//
//  channel  | direction | tdata                          | tuser
//  s        | in        | quote snapshot fields          | trade_changed, book_changed
//  m        | out       | bar result fields              | accepted
//  cfg      | in        | bar_end_time or bar_length     | none
//
// An in-window word with a book update and nonzero sizes reaches the result register
// after it is accepted by way of the queue and then the fair price unit: its multiply
// steps, a load step, forty divide steps and then the taking of the quotient.
// Any other word goes from the queue straight into the result register.
// Reset is synchronous; it clears the bar, the queue and bar_end_time and sets bar_length to 60000.
// While a result waits on the m side the queue keeps taking words until it is full.
module ohlc_bar_aggregator_core #(
    parameter int QUEUE_DEPTH = ohb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [ohb_pkg::TW-1:0]          i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // quote_time, last_price, total_volume, last_volume, total_turnover,
    // open_interest, bid_price, ask_price, bid_size, ask_size
    input  logic [ohb_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // trade_changed, book_changed
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // open_price, high_price, low_price, close_price, bar_volume, bar_turnover,
    // interest_change, fair_price, spread, mid_price, book_depth, zero pad
    output logic [ohb_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // accepted
    output logic                            o_m_tuser
);
    logic               q_valid, q_pop;
    ohb_pkg::t_item     q_item;
    ohb_pkg::t_fair_req fair_req;
    ohb_pkg::t_fair_rsp fair_rsp;

    // Front end classifies each word against the window and queues it.
    ohb_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    // Back end folds one word at a time into the bar.
    ohb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_fair_req(fair_req), .i_fair_rsp(fair_rsp),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    // The fair price is the average of bid and ask, each weighted by the size on the other side.
    ohb_fair u_fair (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(fair_req), .o_rsp(fair_rsp)
    );
endmodule
